// ----- rtl/hvdma_pkg.sv -----
// Shared types and constants for the hblank VRAM DMA controller.
`default_nettype none

package hvdma_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    localparam int unsigned REM_W   = 12;
    localparam int unsigned HBREM_W = $clog2(BLOCK_BYTES) + 1;
    localparam int unsigned SRC_W   = 16;
    localparam int unsigned DOFS_W  = 13;
    localparam int unsigned DST_W   = 14;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_HBLANK = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // register select codes
    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_CTRL   = 3'd4;

    localparam logic [1:0] LCD_MODE_HBLANK = 2'd0;
    localparam logic [1:0] LCD_MODE_XFER   = 2'd3;

    typedef enum logic [1:0] {
        PH_INACTIVE = 2'd0,
        PH_STARTING = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_PAUSED   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                hblank_mode;
        logic [REM_W-1:0]    remaining_bytes;
        logic [HBREM_W-1:0]  hblank_remaining;
        logic [SRC_W-1:0]    source_address;
        logic [DOFS_W-1:0]   dest_offset;
        logic [7:0]          control_value;
        logic                start_pending;
    } t_state;

    typedef struct packed {
        logic [1:0]        byte_count;
        logic [SRC_W-1:0]  first_source;
        logic [DST_W-1:0]  first_dest;
        logic [SRC_W-1:0]  second_source;
        logic [DST_W-1:0]  second_dest;
        logic              vram_write_enable;
        logic [7:0]        control_readback;
        logic [1:0]        dma_state;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/hvdma_step.sv -----
// Next-state and result logic for one DMA transaction.
`default_nettype none

module hvdma_step
    import hvdma_pkg::*;
(
    input  t_state     i_state,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_reg_select,
    input  logic [7:0] i_write_value,
    input  logic [1:0] i_lcd_mode,
    input  logic       i_double_speed,
    input  logic       i_vram_bank,
    output t_state     o_state,
    output t_result    o_result
);

    localparam logic [SRC_W-1:0] HIGH_BASE = 16'hE000;
    localparam logic [SRC_W-1:0] REDIR_OFS = 16'h4000;

    function automatic logic [SRC_W-1:0] redirect(input logic [SRC_W-1:0] a);
        redirect = (a >= HIGH_BASE) ? (a - REDIR_OFS) : a;
    endfunction

    t_state               st;
    logic [1:0]           cnt;
    logic [REM_W-1:0]     rem_new;
    logic [HBREM_W-1:0]   hb_new;
    logic [6:0]           blocks_left;
    logic [DOFS_W-1:0]    dest_next;
    logic [SRC_W-1:0]     src_next;

    always_comb begin
        st          = i_state;
        cnt         = 2'd0;
        rem_new     = i_state.remaining_bytes;
        hb_new      = i_state.hblank_remaining;
        blocks_left = 7'd0;
        dest_next   = i_state.dest_offset + DOFS_W'(1);
        src_next    = i_state.source_address + SRC_W'(1);
        o_result    = '0;

        case (i_operation)
            OP_WRITE: begin
                case (i_reg_select)
                    REG_SRC_HI: st.source_address[15:8] = i_write_value;
                    REG_SRC_LO: st.source_address[7:0]  = i_write_value;
                    REG_DST_HI: st.dest_offset[12:8]    = i_write_value[4:0];
                    REG_DST_LO: st.dest_offset[7:0]     = i_write_value;
                    REG_CTRL: begin
                        st.control_value = i_write_value;
                        st.start_pending = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_HBLANK: begin
                if (i_state.phase == PH_PAUSED) begin
                    st.hblank_remaining = HBREM_W'(BLOCK_BYTES);
                    st.phase            = PH_STARTING;
                end
            end
            OP_TICK: begin
                if (i_state.start_pending) begin
                    if (i_state.phase == PH_INACTIVE || i_state.control_value[7]) begin
                        st.hblank_mode      = i_state.control_value[7];
                        st.remaining_bytes  = REM_W'({1'b0, i_state.control_value[6:0]}
                                              + 8'd1) << BLOCK_SHIFT;
                        st.hblank_remaining = HBREM_W'(BLOCK_BYTES);
                        st.control_value    = {1'b0, i_state.control_value[6:0]};
                        st.phase = (i_state.control_value[7] && i_lcd_mode != LCD_MODE_HBLANK)
                                   ? PH_PAUSED : PH_STARTING;
                    end else begin
                        // running or paused copy stopped by a write with bit 7 clear
                        st.control_value    = i_state.control_value | 8'h80;
                        st.remaining_bytes  = '0;
                        st.hblank_remaining = '0;
                        st.phase            = PH_INACTIVE;
                    end
                    st.start_pending = 1'b0;
                end else if (i_state.phase == PH_STARTING) begin
                    st.phase = PH_ACTIVE;
                end else if (i_state.phase == PH_ACTIVE) begin
                    cnt = i_double_speed ? 2'd1 : 2'd2;
                    if (i_state.remaining_bytes < REM_W'(cnt))
                        cnt = i_state.remaining_bytes[1:0];
                    if (i_state.hblank_mode && i_state.hblank_remaining < HBREM_W'(cnt))
                        cnt = i_state.hblank_remaining[1:0];
                    if (i_state.hblank_mode)
                        hb_new = i_state.hblank_remaining - HBREM_W'(cnt);
                    rem_new = i_state.remaining_bytes - REM_W'(cnt);
                    st.hblank_remaining = hb_new;
                    st.remaining_bytes  = rem_new;
                    st.dest_offset      = i_state.dest_offset + DOFS_W'(cnt);
                    st.source_address   = i_state.source_address + SRC_W'(cnt);

                    if (cnt != 2'd0) begin
                        o_result.first_source = redirect(i_state.source_address);
                        o_result.first_dest   = {i_vram_bank, i_state.dest_offset};
                    end
                    if (cnt == 2'd2) begin
                        o_result.second_source = redirect(src_next);
                        o_result.second_dest   = {i_vram_bank, dest_next};
                    end

                    blocks_left      = 7'(rem_new[REM_W-1:BLOCK_SHIFT] - 8'd1);
                    st.control_value = {1'b0, blocks_left};
                    if (rem_new == '0) begin
                        st.control_value = 8'hFF;
                        st.phase         = PH_INACTIVE;
                    end else if (i_state.hblank_mode && hb_new == '0) begin
                        st.phase = PH_PAUSED;
                    end
                end
            end
            default: ;
        endcase

        o_result.byte_count        = cnt;
        o_result.vram_write_enable = (cnt != 2'd0) && (i_lcd_mode != LCD_MODE_XFER);
        o_result.control_readback  = st.control_value;
        o_result.dma_state         = st.phase;
        o_state                    = st;
    end

endmodule

`default_nettype wire

// ----- rtl/hblank_vram_dma_controller_core.sv -----
// Top level of the hblank VRAM DMA controller.
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one transaction per item:
//    a machine-cycle tick, an hblank start, or a register write.
//  - Output channel (o_out_valid / i_out_stall) returns exactly one result per
//    input transaction: up to two source/destination address pairs, the VRAM
//    write enable, the control readback and the DMA phase.
//  - The result is registered: it appears in the cycle after its input is accepted.
//  - Throughput: one item per cycle while no held result is stalled. The whole state update is one pass of
//    short logic between the state registers and the result register.
//  - The result register parts the two channels: a new item is taken while a
//    result is still offered, as long as that result is being taken in the
//    same cycle. When the receiver stalls with a result held, o_in_stall rises
//    and the held result stays unchanged.
//  - Reset (i_rst_n low, synchronous): phase inactive, control reads 0xFF,
//    counters and addresses cleared, no result pending.
//  - A control write is acted on by the next tick, which moves no bytes.
`default_nettype none

module hblank_vram_dma_controller_core
    import hvdma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_operation,
    input  logic [2:0]       i_reg_select,
    input  logic [7:0]       i_write_value,
    input  logic [1:0]       i_lcd_mode,
    input  logic             i_double_speed,
    input  logic             i_vram_bank,
    // output channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_byte_count,
    output logic [SRC_W-1:0] o_first_source,
    output logic [DST_W-1:0] o_first_dest,
    output logic [SRC_W-1:0] o_second_source,
    output logic [DST_W-1:0] o_second_dest,
    output logic             o_vram_write_enable,
    output logic [7:0]       o_control_readback,
    output logic [1:0]       o_dma_state
);

    // post-reset DMA state: idle, control reads 0xFF
    localparam t_state RESET_STATE = '{
        phase:            PH_INACTIVE,
        hblank_mode:      1'b0,
        remaining_bytes:  '0,
        hblank_remaining: '0,
        source_address:   '0,
        dest_offset:      '0,
        control_value:    8'hFF,
        start_pending:    1'b0
    };

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    // Stall input only while a held result is blocked downstream.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    hvdma_step u_step (
        .i_state        (r_state),
        .i_operation    (i_operation),
        .i_reg_select   (i_reg_select),
        .i_write_value  (i_write_value),
        .i_lcd_mode     (i_lcd_mode),
        .i_double_speed (i_double_speed),
        .i_vram_bank    (i_vram_bank),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // DMA state: advances only on accepted transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RESET_STATE;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_byte_count        = r_result.byte_count;
    assign o_first_source      = r_result.first_source;
    assign o_first_dest        = r_result.first_dest;
    assign o_second_source     = r_result.second_source;
    assign o_second_dest       = r_result.second_dest;
    assign o_vram_write_enable = r_result.vram_write_enable;
    assign o_control_readback  = r_result.control_readback;
    assign o_dma_state         = r_result.dma_state;

endmodule

`default_nettype wire

// ----- rtl/hvdma_checker.sv -----
// Port-level assertions for the hblank VRAM DMA controller, bound to the top.
`default_nettype none

module hvdma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_byte_count,
    input logic [15:0] o_second_source,
    input logic [13:0] o_second_dest,
    input logic        o_vram_write_enable
);

    // an accepted input shows up as a result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("no result after accepted input");

    // a held result must persist while the receiver stalls
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // input is stalled only when a result is blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a write enable never appears without moved bytes
    a_we_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count == 2'd0 |-> !o_vram_write_enable)
        else $error("write enable with no bytes");

    // second address pair is zero unless two bytes moved
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count != 2'd2 |->
            (o_second_source == 16'd0 && o_second_dest == 14'd0))
        else $error("second address set for fewer than two bytes");

endmodule

bind hblank_vram_dma_controller_core hvdma_checker u_hvdma_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_byte_count        (o_byte_count),
    .o_second_source     (o_second_source),
    .o_second_dest       (o_second_dest),
    .o_vram_write_enable (o_vram_write_enable)
);

`default_nettype wire
